// File: sv/olid_pkg.sv
// Shared types and codes for the ordered list insert/delete/find unit.
// No dependencies; used by the cell, the match picker and the top level.
package olid_pkg;

	localparam int NAME_W = 64;
	localparam int ID_W   = 32;

	// Id value that means "no id given" for a find.
	localparam logic [ID_W-1:0] NO_ID = '1;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_FIND   = 2'd2,
		REQ_BAD    = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FULL     = 3'd1,
		ST_BADPOS   = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_NOKEY    = 3'd4
	} status_t;

	// Control word broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;       // shift up from the insert point, load new entry there
		logic del;       // shift down from the delete point
		logic find;      // capture match flag
		logic use_name;  // match on name tag, else on id
	} cell_ctl_t;

endpackage

// File: sv/olid_cell.sv
// One cell of the list chain: holds one entry and its find match flag.
// Depends on olid_pkg.
module olid_cell #(
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  olid_pkg::cell_ctl_t           ctl,
	input  logic [3:0]                    pos_idx,
	input  logic                          in_list,
	input  logic [olid_pkg::NAME_W-1:0]   key,
	input  logic [olid_pkg::ID_W-1:0]     idv,
	input  logic [olid_pkg::NAME_W-1:0]   left_name,
	input  logic [olid_pkg::ID_W-1:0]     left_id,
	input  logic [olid_pkg::NAME_W-1:0]   right_name,
	input  logic [olid_pkg::ID_W-1:0]     right_id,
	output logic [olid_pkg::NAME_W-1:0]   name_q,
	output logic [olid_pkg::ID_W-1:0]     id_q,
	output logic                          hit_q
);

	logic above;
	logic at;
	logic match;

	assign above = IDX > int'(pos_idx);
	assign at    = IDX == int'(pos_idx);
	assign match = in_list &&
		(ctl.use_name ? (name_q == key) : (id_q == idv));

	// Entry storage: take from the left neighbor on insert, the right on delete.
	always_ff @(posedge clk) begin
		if (ctl.ins && above) begin
			name_q <= left_name;
			id_q   <= left_id;
		end else if (ctl.ins && at) begin
			name_q <= key;
			id_q   <= idv;
		end else if (ctl.del && (above || at)) begin
			name_q <= right_name;
			id_q   <= right_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.find) begin
			hit_q <= match;
		end
	end

endmodule

// File: sv/olid_pick.sv
// Picks the lowest-index matching cell and returns its index and entry.
// Depends on olid_pkg.
module olid_pick #(
	parameter int DEPTH = 8
) (
	input  logic [DEPTH-1:0]                  hit,
	input  logic [olid_pkg::NAME_W-1:0]       names [DEPTH],
	input  logic [olid_pkg::ID_W-1:0]         ids   [DEPTH],
	output logic                              any_hit,
	output logic [$clog2(DEPTH)-1:0]          idx,
	output logic [olid_pkg::NAME_W-1:0]       name,
	output logic [olid_pkg::ID_W-1:0]         id
);

	localparam int IW = $clog2(DEPTH);

	logic [DEPTH-1:0] first;

	// Isolate the lowest set bit.
	assign first   = hit & (~hit + DEPTH'(1));
	assign any_hit = |hit;

	always_comb begin
		idx  = '0;
		name = '0;
		id   = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (first[k]) begin
				idx  = idx  | IW'(k);
				name = name | names[k];
				id   = id   | ids[k];
			end
		end
	end

endmodule

// File: sv/ordered_list_insert_delete_find_unit.sv
// Top level of the ordered list unit: a chain of entry cells plus match picker.
// Depends on olid_pkg, olid_cell and olid_pick.
//
// Usage:
//   Request channel: drive req_type, position, name_key and id_value with start
//   high; the word is taken at a rising edge where start is high and busy low.
//   Result channel: done is high for exactly one cycle while status,
//   found_index, found_name, found_id and entry_count hold the result word.
//   The receiver cannot stall; it must take the word in that cycle.
// Timing:
//   Insert, delete and invalid requests: the result word is registered at
//   acceptance and shows in the next cycle; busy stays low, so one such
//   request per cycle while no find is in flight.
//   Find: the cells register their match flags, then the picker selects the
//   lowest matching cell and the result word is registered from it; busy is
//   high while the match flags wait for the picker.
// Reset:
//   arst_n clears the entry count (empty list), the done strobe and busy.
//   Entry contents are not cleared; only entries below the count are read.
module ordered_list_insert_delete_find_unit #(
	parameter int DEPTH = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [3:0]  position,
	input  logic [63:0] name_key,
	input  logic [31:0] id_value,
	output logic        done,
	output logic [2:0]  status,
	output logic [2:0]  found_index,
	output logic [63:0] found_name,
	output logic [31:0] found_id,
	output logic [3:0]  entry_count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int XW = ((CW > 4) ? CW : 4) + 1;

	olid_pkg::req_t      req;
	olid_pkg::cell_ctl_t ctl;
	olid_pkg::status_t   status_imm;
	olid_pkg::status_t   status_q;

	logic          accept;
	logic          full;
	logic          ins_bad;
	logic          del_bad;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;
	logic [3:0]    pos_idx;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;

	logic          find_s1;
	logic          nokey_s1;

	logic [olid_pkg::NAME_W-1:0] name_w [DEPTH];
	logic [olid_pkg::ID_W-1:0]   id_w   [DEPTH];
	logic [DEPTH-1:0]            hit_w;

	logic                        any_hit;
	logic [IW-1:0]               pick_idx;
	logic [olid_pkg::NAME_W-1:0] pick_name;
	logic [olid_pkg::ID_W-1:0]   pick_id;

	logic        done_q;
	logic [2:0]  found_index_q;
	logic [63:0] found_name_q;
	logic [31:0] found_id_q;
	logic [3:0]  entry_count_q;

	// Hold off new requests while a find sits between match and pick.
	assign busy   = find_s1;
	assign accept = start && !busy;
	assign req    = olid_pkg::req_t'(req_type);

	// Range checks on the 1-based position against the current count.
	assign pos_x   = XW'(position);
	assign cnt_x   = XW'(count_q);
	assign full    = count_q == CW'(DEPTH);
	assign ins_bad = (position == 4'd0) || (pos_x > cnt_x + XW'(1));
	assign del_bad = (position == 4'd0) || (pos_x > cnt_x);
	assign pos_idx = position - 4'd1;

	// Classify the request and build the broadcast control word.
	always_comb begin
		ctl          = '0;
		ctl.use_name = name_key != '0;
		status_imm   = olid_pkg::ST_OK;
		count_next   = count_q;
		unique case (req)
			olid_pkg::REQ_INSERT: begin
				if (full) begin
					status_imm = olid_pkg::ST_FULL;
				end else if (ins_bad) begin
					status_imm = olid_pkg::ST_BADPOS;
				end else begin
					ctl.ins    = accept;
					count_next = count_q + CW'(1);
				end
			end
			olid_pkg::REQ_DELETE: begin
				if (del_bad) begin
					status_imm = olid_pkg::ST_BADPOS;
				end else begin
					ctl.del    = accept;
					count_next = count_q - CW'(1);
				end
			end
			olid_pkg::REQ_FIND: begin
				ctl.find = accept;
			end
			olid_pkg::REQ_BAD: begin
				status_imm = olid_pkg::ST_BADPOS;
			end
			default: begin
				status_imm = olid_pkg::ST_BADPOS;
			end
		endcase
	end

	// Chain of cells: each cell sees its left and right neighbor's entry.
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic [olid_pkg::NAME_W-1:0] left_name;
		logic [olid_pkg::ID_W-1:0]   left_id;
		logic [olid_pkg::NAME_W-1:0] right_name;
		logic [olid_pkg::ID_W-1:0]   right_id;
		logic                        in_list;

		if (k == 0) begin : g_first
			assign left_name = '0;
			assign left_id   = '0;
		end else begin : g_left
			assign left_name = name_w[k-1];
			assign left_id   = id_w[k-1];
		end

		if (k == DEPTH - 1) begin : g_last
			assign right_name = '0;
			assign right_id   = '0;
		end else begin : g_right
			assign right_name = name_w[k+1];
			assign right_id   = id_w[k+1];
		end

		assign in_list = CW'(k) < count_q;

		olid_cell #(
			.IDX(k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.pos_idx   (pos_idx),
			.in_list   (in_list),
			.key       (name_key),
			.idv       (id_value),
			.left_name (left_name),
			.left_id   (left_id),
			.right_name(right_name),
			.right_id  (right_id),
			.name_q    (name_w[k]),
			.id_q      (id_w[k]),
			.hit_q     (hit_w[k])
		);
	end

	olid_pick #(
		.DEPTH(DEPTH)
	) u_pick (
		.hit    (hit_w),
		.names  (name_w),
		.ids    (id_w),
		.any_hit(any_hit),
		.idx    (pick_idx),
		.name   (pick_name),
		.id     (pick_id)
	);

	// Control: count, find stage flag, result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			find_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_next;
			end
			find_s1 <= accept && (req == olid_pkg::REQ_FIND);
			done_q  <= find_s1 || (accept && (req != olid_pkg::REQ_FIND));
		end
	end

	// Find stage payload: remember whether no key was given.
	always_ff @(posedge clk) begin
		if (accept) begin
			nokey_s1 <= (name_key == '0) && (id_value == olid_pkg::NO_ID);
		end
	end

	// Result word: find finishes from the picker, the rest at acceptance.
	always_ff @(posedge clk) begin
		if (find_s1) begin
			entry_count_q <= 4'(count_q);
			if (nokey_s1) begin
				status_q      <= olid_pkg::ST_NOKEY;
				found_index_q <= '0;
				found_name_q  <= '0;
				found_id_q    <= '0;
			end else if (any_hit) begin
				status_q      <= olid_pkg::ST_OK;
				found_index_q <= 3'(pick_idx);
				found_name_q  <= pick_name;
				found_id_q    <= pick_id;
			end else begin
				status_q      <= olid_pkg::ST_NOTFOUND;
				found_index_q <= '0;
				found_name_q  <= '0;
				found_id_q    <= '0;
			end
		end else if (accept && (req != olid_pkg::REQ_FIND)) begin
			status_q      <= status_imm;
			found_index_q <= '0;
			found_name_q  <= '0;
			found_id_q    <= '0;
			entry_count_q <= 4'(count_next);
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found_index = found_index_q;
	assign found_name  = found_name_q;
	assign found_id    = found_id_q;
	assign entry_count = entry_count_q;

`ifndef SYNTHESIS
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above list depth");

	a_simple_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req != olid_pkg::REQ_FIND) |=> done && !busy)
		else $error("insert/delete result missing one cycle after acceptance");

	a_find_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req == olid_pkg::REQ_FIND) |=> busy && !done ##1 done)
		else $error("find result not delivered two cycles after acceptance");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("entry count changed without a request");
`endif

endmodule
